@@ design/rfp_pkg.sv @@
// shared types, codes and byte-lane helpers for the relocation field patcher
package rfp_pkg;

   typedef enum logic [3:0] {
      KIND_B1        = 4'd0,
      KIND_B2        = 4'd1,
      KIND_B2HI      = 4'd2,
      KIND_B2HI_SIGN = 4'd3,
      KIND_B3        = 4'd4,
      KIND_B4        = 4'd5,
      KIND_PPC       = 4'd6,
      KIND_PPC_LIS   = 4'd7,
      KIND_VC4       = 4'd8,
      KIND_MIPS      = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_INSN   = 2'd1,
      STATUS_MISALIGNED = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] patched_bytes;
      logic [31:0] old_value;
      logic [31:0] new_value;
      status_type  status;
   } result_type;

   // ppc opcodes and masks
   localparam logic [5:0]  PPC_OP_B      = 6'h12;   // 0x48000000 >> 26
   localparam logic [5:0]  PPC_OP_ADDIS  = 6'h0f;   // 0x3c000000 >> 26
   localparam logic [5:0]  PPC_OP_ORI    = 6'h18;   // 0x60000000 >> 26
   localparam logic [31:0] PPC_B_MASK    = 32'h03ff_fffd;
   // vector-core first halfword patterns
   localparam logic [15:0] VC_LEA_MASK   = 16'hff00;
   localparam logic [15:0] VC_LEA_VAL    = 16'he700;
   localparam logic [15:0] VC_BR_MASK    = 16'hf080;
   localparam logic [15:0] VC_BR_VAL     = 16'h9000;
   localparam logic [15:0] VC_BL_VAL     = 16'h9080;
   localparam logic [15:0] VC_MOV_MASK   = 16'hffe0;
   localparam logic [15:0] VC_MOV_VAL    = 16'he500;
   // mips jump-class opcodes
   localparam logic [5:0]  MIPS_OP_J     = 6'd2;
   localparam logic [5:0]  MIPS_OP_JAL   = 6'd3;
   localparam logic [5:0]  MIPS_OP_JALX  = 6'd29;

   function automatic logic [7:0] get_byte(input logic [63:0] s, input logic [2:0] i);
      return s[{i, 3'b000} +: 8];
   endfunction

   function automatic logic [63:0] put_byte(input logic [63:0] s, input logic [2:0] i,
                                            input logic [7:0] v);
      logic [63:0] r;
      r = s;
      r[{i, 3'b000} +: 8] = v;
      return r;
   endfunction

   function automatic logic [15:0] rd16(input logic [63:0] s, input logic [2:0] off,
                                        input logic bb);
      logic [7:0] a;
      logic [7:0] b;
      a = get_byte(s, off);
      b = get_byte(s, off + 3'd1);
      return bb ? {a, b} : {b, a};
   endfunction

   function automatic logic [63:0] wr16(input logic [63:0] s, input logic [2:0] off,
                                        input logic bb, input logic [15:0] v);
      logic [63:0] r;
      r = put_byte(s, off, bb ? v[15:8] : v[7:0]);
      r = put_byte(r, off + 3'd1, bb ? v[7:0] : v[15:8]);
      return r;
   endfunction

   function automatic logic [31:0] rd32(input logic [63:0] s, input logic [2:0] off,
                                        input logic bb, input logic wb);
      logic [15:0] w0;
      logic [15:0] w1;
      w0 = rd16(s, off, bb);
      w1 = rd16(s, off + 3'd2, bb);
      return wb ? {w0, w1} : {w1, w0};
   endfunction

   function automatic logic [63:0] wr32(input logic [63:0] s, input logic [2:0] off,
                                        input logic bb, input logic wb,
                                        input logic [31:0] v);
      logic [63:0] r;
      r = wr16(s, off, bb, wb ? v[31:16] : v[15:0]);
      r = wr16(r, off + 3'd2, bb, wb ? v[15:0] : v[31:16]);
      return r;
   endfunction

   function automatic logic ppc_memop(input logic [5:0] op);
      logic hit;
      unique case (op)
         6'd14, 6'd32, 6'd34, 6'd36, 6'd38, 6'd40,
         6'd42, 6'd44, 6'd48, 6'd50, 6'd52, 6'd54: hit = 1'b1;
         default:                                  hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

@@ design/rfp_patch.sv @@
// field extraction, relocation add and write-back for one relocation site
module rfp_patch (
   input  logic [63:0]         site_bytes,
   input  rfp_pkg::kind_type   reloc_kind,
   input  logic                bytes_big,
   input  logic                words_big,
   input  logic                pc_relative,
   input  logic [31:0]         symbol_adjust,
   input  logic [31:0]         site_origin,
   output rfp_pkg::result_type result
);
   import rfp_pkg::*;

   logic [31:0] op1;      // first word, caller byte order
   logic [31:0] op2;      // second word, caller byte order
   logic [15:0] vc_head;
   logic [31:0] vc_lo32;  // little-endian word at byte 0
   logic [31:0] vc_sw32;  // word at byte 0, high half first
   logic [31:0] vc_at2;   // little-endian word at byte 2
   logic [31:0] mips_w;
   logic        mips_jump;
   logic [1:0]  form;
   logic        bad;
   logic [31:0] old_val;
   logic [31:0] new_val;
   logic [15:0] hi;
   logic [15:0] lo;
   logic [63:0] patched;
   logic        misaligned;

   assign op1     = rd32(site_bytes, 3'd0, bytes_big, words_big);
   assign op2     = rd32(site_bytes, 3'd4, bytes_big, words_big);
   assign vc_head = rd16(site_bytes, 3'd0, 1'b0);
   assign vc_lo32 = rd32(site_bytes, 3'd0, 1'b0, 1'b0);
   assign vc_sw32 = rd32(site_bytes, 3'd0, 1'b0, 1'b1);
   assign vc_at2  = rd32(site_bytes, 3'd2, 1'b0, 1'b0);
   assign mips_w  = vc_lo32;
   assign mips_jump = (mips_w[31:26] == MIPS_OP_J) || (mips_w[31:26] == MIPS_OP_JAL)
                      || (mips_w[31:26] == MIPS_OP_JALX);

   // extract
   always_comb begin
      form    = 2'd0;
      bad     = 1'b0;
      old_val = '0;
      unique case (reloc_kind)
         KIND_B1: old_val = {24'd0, site_bytes[7:0]};
         KIND_B2, KIND_B2HI, KIND_B2HI_SIGN:
            old_val = {16'd0, rd16(site_bytes, 3'd0, bytes_big)};
         KIND_B3: begin
            if (bytes_big) old_val = {8'd0, site_bytes[7:0], site_bytes[15:8], site_bytes[23:16]};
            else           old_val = {8'd0, site_bytes[23:0]};
         end
         KIND_B4: old_val = op1;
         KIND_PPC: begin
            if (op1[31:26] == PPC_OP_B) begin
               form    = 2'd1;
               old_val = op1 & PPC_B_MASK;
            end else if (op1[31:26] == PPC_OP_ADDIS && op1[20:16] == 5'd0
                         && op2[31:26] == PPC_OP_ORI) begin
               form    = 2'd2;
               old_val = {op1[15:0], op2[15:0]};
            end else if (op1[31:26] == PPC_OP_ADDIS && op1[20:16] == 5'd0
                         && ppc_memop(op2[31:26])) begin
               form    = 2'd3;
               // memory offset is signed, so the high half was bumped
               old_val = {op1[15:0] - {15'd0, op2[15]}, op2[15:0]};
            end else begin
               bad = 1'b1;
            end
         end
         KIND_PPC_LIS: old_val = {{6{op1[25]}}, op1[25:0]};
         KIND_VC4: begin
            if ((vc_head & VC_LEA_MASK) == VC_LEA_VAL) begin
               form    = 2'd1;
               old_val = {{5{vc_at2[26]}}, vc_at2[26:0]};
            end else if ((vc_head & VC_BR_MASK) == VC_BR_VAL) begin
               form    = 2'd2;
               old_val = {{8{vc_sw32[22]}}, vc_sw32[22:0], 1'b0};
            end else if ((vc_head & VC_BR_MASK) == VC_BL_VAL) begin
               form    = 2'd3;
               old_val = {{4{vc_sw32[27]}}, vc_sw32[27:24], vc_sw32[22:0], 1'b0};
            end else if ((vc_head & VC_MOV_MASK) == VC_MOV_VAL) begin
               form    = 2'd0;
               old_val = vc_at2;
            end else begin
               bad = 1'b1;
            end
         end
         KIND_MIPS: begin
            if (mips_jump) old_val = {4'd0, mips_w[25:0], 2'b00};
            else           old_val = {{14{mips_w[15]}}, mips_w[15:0], 2'b00};
         end
         default: bad = 1'b1;
      endcase
   end

   assign new_val    = bad ? 32'd0
                       : old_val + symbol_adjust - (pc_relative ? site_origin : 32'd0);
   assign lo         = new_val[15:0];
   assign misaligned = (reloc_kind == KIND_MIPS) && (new_val[1:0] != 2'b00);

   // insert
   always_comb begin
      patched = site_bytes;
      hi      = new_val[31:16];
      unique case (reloc_kind)
         KIND_B1:        patched = {site_bytes[63:8], new_val[7:0]};
         KIND_B2:        patched = wr16(site_bytes, 3'd0, bytes_big, new_val[15:0]);
         KIND_B2HI:      patched = wr16(site_bytes, 3'd0, bytes_big, new_val[31:16]);
         KIND_B2HI_SIGN: patched = wr16(site_bytes, 3'd0, bytes_big,
                                        new_val[31:16] + {15'd0, new_val[15]});
         KIND_B3: begin
            if (bytes_big)
               patched = {site_bytes[63:24], new_val[7:0], new_val[15:8], new_val[23:16]};
            else
               patched = {site_bytes[63:24], new_val[23:0]};
         end
         KIND_B4: patched = wr32(site_bytes, 3'd0, bytes_big, words_big, new_val);
         KIND_PPC: begin
            if (form == 2'd1) begin
               patched = wr32(site_bytes, 3'd0, bytes_big, words_big,
                              (op1 & ~PPC_B_MASK) | (new_val & PPC_B_MASK));
            end else begin
               if (form == 2'd3 && lo[15]) hi = new_val[31:16] + 16'd1;
               patched = wr32(wr32(site_bytes, 3'd0, bytes_big, words_big, {op1[31:16], hi}),
                              3'd4, bytes_big, words_big, {op2[31:16], lo});
            end
         end
         KIND_PPC_LIS: begin
            if (op1[31] && lo[15]) hi = new_val[31:16] + 16'd1;
            patched = wr32(site_bytes, 3'd0, bytes_big, words_big,
                           {PPC_OP_ADDIS, op1[30:26], 5'd0, hi});
         end
         KIND_VC4: begin
            unique case (form)
               2'd1: patched = wr32(site_bytes, 3'd2, 1'b0, 1'b0,
                                    {vc_at2[31:27], new_val[26:0]});
               2'd2: patched = wr32(site_bytes, 3'd0, 1'b0, 1'b1,
                                    {vc_sw32[31:23], new_val[23:1]});
               2'd3: patched = wr32(site_bytes, 3'd0, 1'b0, 1'b1,
                                    {vc_sw32[31:28], new_val[27:24], vc_sw32[23],
                                     new_val[23:1]});
               default: patched = wr32(site_bytes, 3'd2, 1'b0, 1'b0, new_val);
            endcase
         end
         KIND_MIPS: begin
            if (!misaligned) begin
               if (mips_jump)
                  patched = wr32(site_bytes, 3'd0, 1'b0, 1'b0, {mips_w[31:26], new_val[27:2]});
               else
                  patched = wr32(site_bytes, 3'd0, 1'b0, 1'b0, {mips_w[31:16], new_val[17:2]});
            end
         end
         default: patched = site_bytes;
      endcase
      if (bad) patched = site_bytes;
   end

   always_comb begin
      result.patched_bytes = patched;
      result.old_value     = bad ? 32'd0 : old_val;
      result.new_value     = new_val;
      if (bad)             result.status = STATUS_BAD_INSN;
      else if (misaligned) result.status = STATUS_MISALIGNED;
      else                 result.status = STATUS_OK;
   end

endmodule

@@ design/relocation_field_patcher.sv @@
// top level: input register, patch logic and result register
// Patches one relocation site per clock. An item is taken when start is high and
// busy is low; busy is high only while reset is held and in the first cycle after
// it, so a new item may be started on every clock. The result appears on the rsp_
// ports with rsp_valid high for exactly one cycle, once the item has passed from the
// input register, which the taking edge loads, through the patch logic into the
// result register. The receiver cannot hold results off and must take each one in
// the cycle it is shown.
module relocation_field_patcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_site_bytes,
   input  logic [3:0]  req_reloc_kind,
   input  logic        req_bytes_big,
   input  logic        req_words_big,
   input  logic        req_pc_relative,
   input  logic [31:0] req_symbol_adjust,
   input  logic [31:0] req_site_origin,
   output logic        rsp_valid,
   output logic [63:0] rsp_patched_bytes,
   output logic [31:0] rsp_old_value,
   output logic [31:0] rsp_new_value,
   output logic [1:0]  rsp_status
);
   import rfp_pkg::*;

   logic        busy_ff;
   logic        in_valid_ff;
   logic [63:0] in_site_bytes_ff;
   kind_type    in_reloc_kind_ff;
   logic        in_bytes_big_ff;
   logic        in_words_big_ff;
   logic        in_pc_relative_ff;
   logic [31:0] in_symbol_adjust_ff;
   logic [31:0] in_site_origin_ff;
   logic        take;
   result_type  result_in;
   logic        rsp_valid_ff;
   result_type  result_ff;

   assign take = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         in_valid_ff  <= take;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_site_bytes_ff    <= req_site_bytes;
         in_reloc_kind_ff    <= kind_type'(req_reloc_kind);
         in_bytes_big_ff     <= req_bytes_big;
         in_words_big_ff     <= req_words_big;
         in_pc_relative_ff   <= req_pc_relative;
         in_symbol_adjust_ff <= req_symbol_adjust;
         in_site_origin_ff   <= req_site_origin;
      end
      if (in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   rfp_patch u_patch (
      .site_bytes    (in_site_bytes_ff),
      .reloc_kind    (in_reloc_kind_ff),
      .bytes_big     (in_bytes_big_ff),
      .words_big     (in_words_big_ff),
      .pc_relative   (in_pc_relative_ff),
      .symbol_adjust (in_symbol_adjust_ff),
      .site_origin   (in_site_origin_ff),
      .result        (result_in)
   );

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_patched_bytes = result_ff.patched_bytes;
   assign rsp_old_value     = result_ff.old_value;
   assign rsp_new_value     = result_ff.new_value;
   assign rsp_status        = result_ff.status;

   a_accept_flows : assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted item did not reach the input register");

   a_result_from_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(in_valid_ff))
      else $error("result strobe without an item behind it");

   a_bad_insn_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status == STATUS_BAD_INSN) |->
         (result_ff.old_value == 32'd0 && result_ff.new_value == 32'd0
          && result_ff.patched_bytes == $past(in_site_bytes_ff)))
      else $error("unrecognised item must pass bytes and report zero values");

   a_misaligned_untouched : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status == STATUS_MISALIGNED) |->
         (result_ff.new_value[1:0] != 2'b00
          && result_ff.patched_bytes == $past(in_site_bytes_ff)))
      else $error("misaligned mips item must leave bytes unchanged");

endmodule
